// ===== sv/mva_pkg.sv =====
`timescale 1ns / 1ps

package mva_pkg;

    // fixed field width and queue depth
    localparam int VOICE_W = 5;
    localparam int QDEPTH  = 2;

    // midi commands (upper nibble of status)
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_CTRL     = 4'hB;

    // controller numbers
    localparam logic [6:0] CC_SUSTAIN   = 7'd64;
    localparam logic [6:0] CC_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_RESET     = 7'd121;
    localparam logic [6:0] CC_NOTES_OFF = 7'd123;

    // result actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STOP  = 1'b1;

    typedef enum logic [2:0] {
        OP_KEY_OFF,
        OP_KEY_ON,
        OP_PEDAL,
        OP_ALL_OFF,
        OP_PEDAL_CLR
    } op_kind_t;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] data1;
        logic [6:0] data2;
        logic       double_voice;
    } msg_t;

    typedef struct packed {
        logic               action;
        logic [VOICE_W-1:0] voice;
        logic [3:0]         channel;
        logic [6:0]         note;
        logic [6:0]         velocity;
        logic               second_half;
        logic               last;
    } res_t;

    // classified message as handed from front to back
    typedef struct packed {
        op_kind_t   kind;
        logic [3:0] channel;
        logic [6:0] note;
        logic [6:0] value;
        logic       flag;   // double voice for key-on, pedal down for sustain
    } op_t;

endpackage

// ===== sv/mva_front.sv =====
`timescale 1ns / 1ps

module mva_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mva_pkg::msg_t msg,
    output logic          q_valid,
    output mva_pkg::op_t  q_op,
    input  logic          pop
);
    import mva_pkg::*;

    op_t        op_dec;
    logic       keep;
    logic       push;
    op_t        entry_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // classify the message; anything without an effect is dropped here
    always_comb
    begin
        op_dec.kind    = OP_KEY_OFF;
        op_dec.channel = msg.status[3:0];
        op_dec.note    = msg.data1;
        op_dec.value   = msg.data2;
        op_dec.flag    = msg.double_voice;
        keep           = 1'b0;
        case (msg.status[7:4])
            CMD_NOTE_OFF:
            begin
                keep = 1'b1;
            end
            CMD_NOTE_ON:
            begin
                keep = 1'b1;
                if (msg.data2 != 7'd0)
                begin
                    op_dec.kind = OP_KEY_ON;
                end
            end
            CMD_CTRL:
            begin
                case (msg.data1)
                    CC_SUSTAIN:
                    begin
                        keep         = 1'b1;
                        op_dec.kind  = OP_PEDAL;
                        op_dec.flag  = msg.data2[6];
                    end
                    CC_SOUND_OFF, CC_NOTES_OFF:
                    begin
                        keep        = 1'b1;
                        op_dec.kind = OP_ALL_OFF;
                    end
                    CC_RESET:
                    begin
                        keep        = 1'b1;
                        op_dec.kind = OP_PEDAL_CLR;
                    end
                    default:
                    begin
                        keep = 1'b0;
                    end
                endcase
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign busy    = (count_reg == 2'(QDEPTH));
    assign push    = start && !busy && keep;
    assign q_valid = (count_reg != 2'd0);
    assign q_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= op_dec;
        end
    end

endmodule

// ===== sv/mva_back.sv =====
`timescale 1ns / 1ps

module mva_back #(
    parameter int VOICES = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  mva_pkg::op_t  q_op,
    output logic          pop,
    output logic          strobe,
    output mva_pkg::res_t result
);
    import mva_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PICK,
        S_START,
        S_FLUSH
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    res_t             pend_reg;
    res_t             pend_next;
    logic             strobe_reg;
    logic             strobe_next;
    res_t             result_reg;
    res_t             result_next;
    logic [31:0]      next_age_reg;
    logic [31:0]      next_age_next;
    logic             pedal_reg [16];

    op_t              op_reg;
    op_t              op_next;
    logic [IDX_W-1:0] pick_reg;
    logic [IDX_W-1:0] pick_next;
    logic             half_reg;
    logic             half_next;
    logic [IDX_W-1:0] best_idx_reg;
    logic             best_held_reg;
    logic [31:0]      best_age_reg;
    logic [3:0]       best_channel_reg;
    logic [6:0]       best_note_reg;
    logic             best_half_reg;

    // voice table
    logic             active_reg  [VOICES];
    logic             held_reg    [VOICES];
    logic [3:0]       channel_reg [VOICES];
    logic [6:0]       note_reg    [VOICES];
    logic             vhalf_reg   [VOICES];
    logic [31:0]      age_reg     [VOICES];

    logic             cur_active;
    logic             cur_held;
    logic [3:0]       cur_channel;
    logic [6:0]       cur_note;
    logic             cur_half;
    logic [31:0]      cur_age;
    logic             better;
    logic [IDX_W-1:0] cand_idx;
    logic [3:0]       cand_channel;
    logic [6:0]       cand_note;
    logic             cand_half;

    logic             walk_stop;
    logic             emit_en;
    res_t             emit_res;
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
    logic             hold_en;
    logic             start_en;
    logic             pedal_wr;

    assign cur_active  = active_reg[idx_reg];
    assign cur_held    = held_reg[idx_reg];
    assign cur_channel = channel_reg[idx_reg];
    assign cur_note    = note_reg[idx_reg];
    assign cur_half    = vhalf_reg[idx_reg];
    assign cur_age     = age_reg[idx_reg];

    // steal order: pedal-held first, then oldest, lowest index on ties
    assign better = (idx_reg == '0) || (cur_held && !best_held_reg) ||
                    ((cur_held == best_held_reg) && (cur_age < best_age_reg));

    assign cand_idx     = better ? idx_reg     : best_idx_reg;
    assign cand_channel = better ? cur_channel : best_channel_reg;
    assign cand_note    = better ? cur_note    : best_note_reg;
    assign cand_half    = better ? cur_half    : best_half_reg;

    always_comb
    begin
        walk_stop = 1'b0;
        hold_en   = 1'b0;
        case (op_reg.kind)
            OP_KEY_OFF:
            begin
                if (cur_active && !cur_held && cur_channel == op_reg.channel &&
                    cur_note == op_reg.note)
                begin
                    if (pedal_reg[op_reg.channel])
                    begin
                        hold_en = 1'b1;
                    end
                    else
                    begin
                        walk_stop = 1'b1;
                    end
                end
            end
            OP_ALL_OFF:
            begin
                walk_stop = cur_active && cur_channel == op_reg.channel;
            end
            OP_PEDAL:
            begin
                walk_stop = cur_active && cur_held && cur_channel == op_reg.channel;
            end
            default:
            begin
                walk_stop = 1'b0;
            end
        endcase
        if (state_reg != S_WALK)
        begin
            walk_stop = 1'b0;
            hold_en   = 1'b0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        next_age_next   = next_age_reg;
        op_next         = op_reg;
        pick_next       = pick_reg;
        half_next       = half_reg;
        emit_en         = 1'b0;
        emit_res        = '0;
        clr_en          = 1'b0;
        clr_idx         = idx_reg;
        start_en        = 1'b0;
        pedal_wr        = 1'b0;
        pop             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    op_next  = q_op;
                    idx_next = '0;
                    case (q_op.kind)
                        OP_KEY_ON:
                        begin
                            half_next  = 1'b0;
                            state_next = S_PICK;
                        end
                        OP_PEDAL:
                        begin
                            pedal_wr   = 1'b1;
                            state_next = q_op.flag ? S_IDLE : S_WALK;
                        end
                        OP_PEDAL_CLR:
                        begin
                            pedal_wr   = 1'b1;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_WALK;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (walk_stop)
                begin
                    clr_en   = 1'b1;
                    emit_en  = 1'b1;
                    emit_res = '{action: ACT_STOP, voice: VOICE_W'(idx_reg),
                                 channel: cur_channel, note: cur_note,
                                 velocity: 7'd0, second_half: cur_half, last: 1'b0};
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_PICK:
            begin
                if (!cur_active)
                begin
                    pick_next  = idx_reg;
                    state_next = S_START;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    // table full: steal the best candidate
                    clr_en     = 1'b1;
                    clr_idx    = cand_idx;
                    emit_en    = 1'b1;
                    emit_res   = '{action: ACT_STOP, voice: VOICE_W'(cand_idx),
                                   channel: cand_channel, note: cand_note,
                                   velocity: 7'd0, second_half: cand_half, last: 1'b0};
                    pick_next  = cand_idx;
                    state_next = S_START;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_START:
            begin
                start_en      = 1'b1;
                next_age_next = next_age_reg + 32'd1;
                emit_en       = 1'b1;
                emit_res      = '{action: ACT_START, voice: VOICE_W'(pick_reg),
                                  channel: op_reg.channel, note: op_reg.note,
                                  velocity: op_reg.value, second_half: half_reg,
                                  last: 1'b0};
                if (!half_reg && op_reg.flag)
                begin
                    half_next  = 1'b1;
                    idx_next   = '0;
                    state_next = S_PICK;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    strobe_next      = 1'b1;
                    result_next      = pend_reg;
                    result_next.last = 1'b1;
                    pend_valid_next  = 1'b0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a result is held back in a pending register so that last can be marked
        if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                strobe_next      = 1'b1;
                result_next      = pend_reg;
                result_next.last = 1'b0;
            end
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            result_reg     <= '0;
            next_age_reg   <= 32'd0;
            for (int c = 0; c < 16; c++)
            begin
                pedal_reg[c] <= 1'b0;
            end
            for (int v = 0; v < VOICES; v++)
            begin
                active_reg[v] <= 1'b0;
                held_reg[v]   <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            result_reg     <= result_next;
            next_age_reg   <= next_age_next;
            if (pedal_wr)
            begin
                pedal_reg[q_op.channel] <= (q_op.kind == OP_PEDAL) && q_op.flag;
            end
            if (start_en)
            begin
                active_reg[pick_reg] <= 1'b1;
                held_reg[pick_reg]   <= 1'b0;
            end
            if (clr_en)
            begin
                active_reg[clr_idx] <= 1'b0;
                held_reg[clr_idx]   <= 1'b0;
            end
            if (hold_en)
            begin
                held_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pick_reg   <= pick_next;
        half_reg   <= half_next;
        pend_reg   <= pend_next;
        if (state_reg == S_PICK && cur_active && better)
        begin
            best_idx_reg     <= idx_reg;
            best_held_reg    <= cur_held;
            best_age_reg     <= cur_age;
            best_channel_reg <= cur_channel;
            best_note_reg    <= cur_note;
            best_half_reg    <= cur_half;
        end
        if (start_en)
        begin
            channel_reg[pick_reg] <= op_reg.channel;
            note_reg[pick_reg]    <= op_reg.note;
            vhalf_reg[pick_reg]   <= half_reg;
            age_reg[pick_reg]     <= next_age_reg;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ===== sv/midi_voice_allocator.sv =====
`timescale 1ns / 1ps

// midi voice allocator: takes one midi channel message per beat on start/busy
// and reports every synth voice it stops or starts, at most one result per cycle on
// strobe/result; the receiver has no way to stall, so results must be taken
// the cycle they appear, and last marks the final result of a message. a
// two-deep message queue sits between the decoder and the voice walker, so
// busy rises only when two messages wait behind the one being worked on.
// messages with no effect (data bytes, unhandled commands and controllers)
// are dropped at the decoder and never reach the queue. the walker steps
// through the voices one at a time on the single table read port: a note-off,
// all-notes-off or pedal release walks the whole table, a sustain press or
// reset-all-controllers walks none, and a note-on searches the table once
// for each voice it starts (twice for a doubled note)
module midi_voice_allocator #(
    parameter int VOICES = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mva_pkg::msg_t msg,
    output logic          strobe,
    output mva_pkg::res_t result
);
    import mva_pkg::*;

    logic q_valid;
    op_t  q_op;
    logic pop;

    // decode and queue
    mva_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .msg     (msg),
        .q_valid (q_valid),
        .q_op    (q_op),
        .pop     (pop)
    );

    // voice table walker, steal search and result stream
    mva_back #(
        .VOICES (VOICES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (q_op),
        .pop     (pop),
        .strobe  (strobe),
        .result  (result)
    );

    // a started voice always carries a nonzero velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.action == ACT_START |-> result.velocity != 7'd0)
        else $error("voice started with zero velocity");

    // the walker never dequeues from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("dequeue from empty queue");

    // reported voice index stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> int'(result.voice) < VOICES)
        else $error("voice index out of range");

    // busy only rises after a beat was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted beat");

endmodule
